@@ hdl/wgb_pkg.sv @@
// shared types and constants for the weighted grid binning core
`default_nettype none

package wgb_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned DENS_W    = 32;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W    = 64;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [DENS_W-1:0] DENS_MAX = {1'b0, {(DENS_W-1){1'b1}}};
    localparam logic [DENS_W-1:0] DENS_MIN = {1'b1, {(DENS_W-1){1'b0}}};

    localparam logic [COORD_W-1:0] RST_X_LOWER       = 32'd0;
    localparam logic [COORD_W-1:0] RST_X_UPPER       = 32'd4194304;
    localparam logic [COORD_W-1:0] RST_Y_LOWER       = 32'd0;
    localparam logic [COORD_W-1:0] RST_Y_UPPER       = 32'd4194304;
    localparam logic [COORD_W-1:0] RST_INV_BIN_WIDTH = 32'd65536;
    localparam logic [COORD_W-1:0] RST_DENSITY_SCALE = 32'd65536;

    typedef enum logic {
        FUNC_DEPOSIT = 1'b0,
        FUNC_READ    = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LOWER         = 3'd0,
        CFG_X_UPPER         = 3'd1,
        CFG_Y_LOWER         = 3'd2,
        CFG_Y_UPPER         = 3'd3,
        CFG_INV_BIN_WIDTH_X = 3'd4,
        CFG_INV_BIN_WIDTH_Y = 3'd5,
        CFG_DENSITY_SCALE   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_ADDR,
        S_READ,
        S_UPDATE,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mult;
    } t_bin_ctl;

endpackage

`default_nettype wire

@@ hdl/weighted_grid_binning_core.sv @@
// Weighted 2D histogram core: deposit items add a weight to the grid cell of a point inside
// the configured box, read items return a cell sum and its density and clear the cell. One
// item is in flight at a time; the sequencer walks each item through the box test, the bin
// index multiply, the registered grid memory read, the write-back and the split density
// multiply before its result is loaded into the output register. The output register lets
// the next item be accepted while a result still waits.
// After reset the grid memory is cleared one entry per cycle; no item is accepted during
// the clear, and configuration writes are taken at any time.
`default_nettype none

module weighted_grid_binning_core #(
    parameter int unsigned GRID_X = 64,
    parameter int unsigned GRID_Y = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wgb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wgb_pkg::COORD_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic signed [wgb_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [wgb_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [wgb_pkg::COORD_W-1:0]  i_weight,
    input  logic [wgb_pkg::IDX_W-1:0]           i_cell_col,
    input  logic [wgb_pkg::IDX_W-1:0]           i_cell_row,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_in_box,
    output logic [wgb_pkg::IDX_W-1:0]           o_bin_col,
    output logic [wgb_pkg::IDX_W-1:0]           o_bin_row,
    output logic signed [wgb_pkg::SUM_W-1:0]    o_cell_sum,
    output logic signed [wgb_pkg::DENS_W-1:0]   o_density
);
    import wgb_pkg::*;

    localparam int unsigned DEPTH = GRID_X * GRID_Y;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int unsigned RW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;

    localparam logic [COORD_W-1:0] X_LAST    = COORD_W'(GRID_X - 1);
    localparam logic [COORD_W-1:0] Y_LAST    = COORD_W'(GRID_Y - 1);
    localparam logic [COORD_W-1:0] X_COUNT   = COORD_W'(GRID_X);
    localparam logic [COORD_W-1:0] Y_COUNT   = COORD_W'(GRID_Y);
    localparam logic [AW-1:0]      GRID_Y_A  = AW'(GRID_Y);
    localparam logic [AW-1:0]      ADDR_LAST = AW'(DEPTH - 1);

    // configuration
    logic signed [COORD_W-1:0] r_x_lower;
    logic signed [COORD_W-1:0] r_x_upper;
    logic signed [COORD_W-1:0] r_y_lower;
    logic signed [COORD_W-1:0] r_y_upper;
    logic [COORD_W-1:0]        r_inv_x;
    logic [COORD_W-1:0]        r_inv_y;
    logic [COORD_W-1:0]        r_dens_scale;

    // sequencer
    t_state r_state;
    t_state n_state;
    logic [AW-1:0] r_clr_addr;

    // item registers
    logic                      r_func;
    logic signed [COORD_W-1:0] r_pos_x;
    logic signed [COORD_W-1:0] r_pos_y;
    logic signed [COORD_W-1:0] r_weight;
    logic [IDX_W-1:0]          r_cell_col;
    logic [IDX_W-1:0]          r_cell_row;

    logic              r_hit;
    logic [AW-1:0]     r_addr;
    logic [IDX_W-1:0]  r_col6;
    logic [IDX_W-1:0]  r_row6;
    logic              r_in_box;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_mag;
    logic              r_neg;

    // output register
    logic              r_out_valid;
    logic              r_out_in_box;
    logic [IDX_W-1:0]  r_out_col;
    logic [IDX_W-1:0]  r_out_row;
    logic [SUM_W-1:0]  r_out_sum;
    logic [DENS_W-1:0] r_out_dens;

    // control
    t_bin_ctl w_bin_ctl;
    logic     w_accept;
    logic     w_mem_re;
    logic     w_mem_we;
    logic     w_scale_load;
    logic     w_out_free;
    logic     w_out_load;

    logic               w_x_inside;
    logic               w_y_inside;
    logic [COORD_W-1:0] w_x_bin;
    logic [COORD_W-1:0] w_y_bin;

    logic [CW-1:0]        w_x_col;
    logic [RW-1:0]        w_y_row;
    logic [CW+IDX_W-1:0]  w_x_ext;
    logic [RW+IDX_W-1:0]  w_y_ext;
    logic [CW+IDX_W-1:0]  w_rd_col_ext;
    logic [RW+IDX_W-1:0]  w_rd_row_ext;
    logic                 w_rd_valid;
    logic                 w_dep_hit;
    logic                 w_hit;
    logic [CW-1:0]        w_col;
    logic [RW-1:0]        w_row;
    logic [IDX_W-1:0]     w_col6;
    logic [IDX_W-1:0]     w_row6;
    logic [AW-1:0]        w_addr;

    logic [SUM_W-1:0]  w_rdata;
    logic [SUM_W:0]    w_acc;
    logic [SUM_W-1:0]  w_acc_sat;
    logic [SUM_W-1:0]  w_upd_data;
    logic              w_read_hit;
    logic [SUM_W-1:0]  w_abs;
    logic [AW-1:0]     w_waddr;
    logic [SUM_W-1:0]  w_wdata;
    logic [DENS_W-1:0] w_density;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lower    <= RST_X_LOWER;
            r_x_upper    <= RST_X_UPPER;
            r_y_lower    <= RST_Y_LOWER;
            r_y_upper    <= RST_Y_UPPER;
            r_inv_x      <= RST_INV_BIN_WIDTH;
            r_inv_y      <= RST_INV_BIN_WIDTH;
            r_dens_scale <= RST_DENSITY_SCALE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_LOWER:         r_x_lower    <= i_cfg_data;
                CFG_X_UPPER:         r_x_upper    <= i_cfg_data;
                CFG_Y_LOWER:         r_y_lower    <= i_cfg_data;
                CFG_Y_UPPER:         r_y_upper    <= i_cfg_data;
                CFG_INV_BIN_WIDTH_X: r_inv_x      <= i_cfg_data;
                CFG_INV_BIN_WIDTH_Y: r_inv_y      <= i_cfg_data;
                CFG_DENSITY_SCALE:   r_dens_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  n_state = (r_clr_addr == ADDR_LAST) ? S_IDLE : S_CLEAR;
            S_IDLE:   n_state = i_valid ? S_DIFF : S_IDLE;
            S_DIFF:   n_state = S_MUL;
            S_MUL:    n_state = S_ADDR;
            S_ADDR:   n_state = S_READ;
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_SCALE;
            S_SCALE:  n_state = S_DONE;
            S_DONE:   n_state = w_out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready        = (r_state == S_IDLE);
        w_bin_ctl.load = (r_state == S_DIFF);
        w_bin_ctl.mult = (r_state == S_MUL);
        w_mem_re       = (r_state == S_READ);
        w_mem_we       = (r_state == S_CLEAR) || ((r_state == S_UPDATE) && r_hit);
        w_scale_load   = (r_state == S_SCALE);
        w_out_load     = (r_state == S_DONE) && w_out_free;
    end

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= i_func;
            r_pos_x    <= i_pos_x;
            r_pos_y    <= i_pos_y;
            r_weight   <= i_weight;
            r_cell_col <= i_cell_col;
            r_cell_row <= i_cell_row;
        end
    end

    wgb_bin u_bin_x (
        .i_clk    (i_clk),
        .i_ctl    (w_bin_ctl),
        .i_coord  (r_pos_x),
        .i_lower  (r_x_lower),
        .i_upper  (r_x_upper),
        .i_inv    (r_inv_x),
        .o_inside (w_x_inside),
        .o_bin    (w_x_bin)
    );

    wgb_bin u_bin_y (
        .i_clk    (i_clk),
        .i_ctl    (w_bin_ctl),
        .i_coord  (r_pos_y),
        .i_lower  (r_y_lower),
        .i_upper  (r_y_upper),
        .i_inv    (r_inv_y),
        .o_inside (w_y_inside),
        .o_bin    (w_y_bin)
    );

    // clamp bins, pick cell, form address
    always_comb begin
        w_x_col      = (w_x_bin > X_LAST) ? X_LAST[CW-1:0] : w_x_bin[CW-1:0];
        w_y_row      = (w_y_bin > Y_LAST) ? Y_LAST[RW-1:0] : w_y_bin[RW-1:0];
        w_x_ext      = (CW+IDX_W)'(w_x_col);
        w_y_ext      = (RW+IDX_W)'(w_y_row);
        w_rd_col_ext = (CW+IDX_W)'(r_cell_col);
        w_rd_row_ext = (RW+IDX_W)'(r_cell_row);
        w_rd_valid   = (COORD_W'(r_cell_col) < X_COUNT) && (COORD_W'(r_cell_row) < Y_COUNT);
        w_dep_hit    = w_x_inside && w_y_inside;
        if (r_func == FUNC_READ) begin
            w_hit  = w_rd_valid;
            w_col  = w_rd_col_ext[CW-1:0];
            w_row  = w_rd_row_ext[RW-1:0];
            w_col6 = r_cell_col;
            w_row6 = r_cell_row;
        end else begin
            w_hit  = w_dep_hit;
            w_col  = w_x_col;
            w_row  = w_y_row;
            w_col6 = w_dep_hit ? w_x_ext[IDX_W-1:0] : '0;
            w_row6 = w_dep_hit ? w_y_ext[IDX_W-1:0] : '0;
        end
        w_addr = AW'(w_col) * GRID_Y_A + AW'(w_row);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_hit    <= w_hit;
            r_addr   <= w_addr;
            r_col6   <= w_col6;
            r_row6   <= w_row6;
            r_in_box <= (r_func == FUNC_READ) || w_dep_hit;
        end
    end

    wgb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // saturating accumulate, or clear on read
    always_comb begin
        w_acc      = {w_rdata[SUM_W-1], w_rdata} + (SUM_W+1)'(r_weight);
        if (w_acc[SUM_W] != w_acc[SUM_W-1]) begin
            w_acc_sat = w_acc[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_acc_sat = w_acc[SUM_W-1:0];
        end
        w_upd_data = (r_func == FUNC_READ) ? '0 : w_acc_sat;
        w_read_hit = (r_func == FUNC_READ) && r_hit;
        w_abs      = w_rdata[SUM_W-1] ? (~w_rdata + SUM_W'(1)) : w_rdata;
        w_waddr    = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
        w_wdata    = (r_state == S_CLEAR) ? '0 : w_upd_data;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_sum <= w_read_hit ? w_rdata : '0;
            r_mag <= w_read_hit ? w_abs : '0;
            r_neg <= w_read_hit && w_rdata[SUM_W-1];
        end
    end

    wgb_scale u_scale (
        .i_clk     (i_clk),
        .i_load    (w_scale_load),
        .i_mag     (r_mag),
        .i_neg     (r_neg),
        .i_scale   (r_dens_scale),
        .o_density (w_density)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_in_box <= r_in_box;
            r_out_col    <= r_col6;
            r_out_row    <= r_row6;
            r_out_sum    <= r_sum;
            r_out_dens   <= w_density;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_in_box   = r_out_in_box;
    assign o_bin_col  = r_out_col;
    assign o_bin_row  = r_out_row;
    assign o_cell_sum = r_out_sum;
    assign o_density  = r_out_dens;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another is in flight");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_box) |-> (o_bin_col == '0 && o_bin_row == '0 && o_cell_sum == '0))
        else $error("skipped point carries nonzero fields");

    a_zero_density: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cell_sum == '0) |-> (o_density == '0))
        else $error("density nonzero for empty cell");

endmodule

`default_nettype wire

@@ hdl/wgb_bin.sv @@
// box test and bin index multiply for one coordinate axis
`default_nettype none

module wgb_bin (
    input  logic                                i_clk,
    input  wgb_pkg::t_bin_ctl                   i_ctl,
    input  logic signed [wgb_pkg::COORD_W-1:0]  i_coord,
    input  logic signed [wgb_pkg::COORD_W-1:0]  i_lower,
    input  logic signed [wgb_pkg::COORD_W-1:0]  i_upper,
    input  logic        [wgb_pkg::COORD_W-1:0]  i_inv,
    output logic                                o_inside,
    output logic        [wgb_pkg::COORD_W-1:0]  o_bin
);
    import wgb_pkg::*;

    logic                 r_inside;
    logic [COORD_W-1:0]   r_diff;
    logic [COORD_W-1:0]   r_bin;
    logic [COORD_W:0]     w_diff_full;
    logic [PROD_W-1:0]    w_prod;

    assign w_diff_full = {i_coord[COORD_W-1], i_coord} - {i_lower[COORD_W-1], i_lower};
    assign w_prod      = r_diff * i_inv;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_inside <= (i_coord >= i_lower) && (i_coord <= i_upper);
            r_diff   <= w_diff_full[COORD_W-1:0];
        end
        if (i_ctl.mult) begin
            r_bin <= w_prod[PROD_W-1:PROD_W-COORD_W];
        end
    end

    assign o_inside = r_inside;
    assign o_bin    = r_bin;

endmodule

`default_nettype wire

@@ hdl/wgb_mem.sv @@
// accumulator grid memory, one write and one registered read port
`default_nettype none

module wgb_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [wgb_pkg::SUM_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [wgb_pkg::SUM_W-1:0] o_rdata
);
    import wgb_pkg::*;

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/wgb_scale.sv @@
// density scaling: split multiply, floor rounding and saturation
`default_nettype none

module wgb_scale (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [wgb_pkg::SUM_W-1:0]   i_mag,
    input  logic                        i_neg,
    input  logic [wgb_pkg::COORD_W-1:0] i_scale,
    output logic [wgb_pkg::DENS_W-1:0]  o_density
);
    import wgb_pkg::*;

    localparam logic [PROD_W-1:0] POS_LIMIT = 64'd2147483647;
    localparam logic [PROD_W-1:0] NEG_LIMIT = 64'd2147483648;

    logic [PROD_W-1:0] r_hi;
    logic [PROD_W-1:0] r_lo;
    logic              r_neg;
    logic [PROD_W-1:0] w_hi;
    logic [PROD_W-1:0] w_lo;
    logic [PROD_W-1:0] w_q;
    logic              w_round;

    assign w_hi = i_mag * i_scale[COORD_W-1:16];
    assign w_lo = i_mag * i_scale[15:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hi  <= w_hi;
            r_lo  <= w_lo;
            r_neg <= i_neg;
        end
    end

    // negative values round away from zero in magnitude, i.e. toward minus infinity
    assign w_round = r_neg && (r_lo[15:0] != 16'd0);
    assign w_q     = r_hi + (r_lo >> 16) + PROD_W'(w_round);

    always_comb begin
        if (!r_neg) begin
            o_density = (w_q > POS_LIMIT) ? DENS_MAX : w_q[DENS_W-1:0];
        end else begin
            o_density = (w_q > NEG_LIMIT) ? DENS_MIN : (~w_q[DENS_W-1:0] + 32'd1);
        end
    end

endmodule

`default_nettype wire
